### rtl/bds_pkg.sv
package bds_pkg;

  localparam int unsigned PIXEL_W     = 8;
  localparam int unsigned ROW_WIDTH_W = 13;
  localparam int unsigned OUT_SIZE_W  = 11;
  localparam int unsigned COL_W       = 12;
  localparam int unsigned HSUM_W      = 10;
  localparam int unsigned TOT_W       = 12;
  localparam int unsigned CFG_DATA_W  = 13;
  localparam int unsigned CFG_IDX_W   = 2;

  // column index as wide as the largest supported line store
  localparam int unsigned KIDX_W = 12;

  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = 2;
  localparam int unsigned Q_CNT_W = 3;

  localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST = 13'd640;
  localparam logic [OUT_SIZE_W-1:0]  OUT_COLS_RST  = 11'd320;
  localparam logic [OUT_SIZE_W-1:0]  OUT_ROWS_RST  = 11'd240;
  localparam logic                   MODE_RST      = 1'b0;

  localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_MAX = 13'd4096;
  localparam logic [OUT_SIZE_W-1:0]  OUT_ROWS_MAX  = 11'd1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_WIDTH = 2'd0,
    CFG_OUT_COLS  = 2'd1,
    CFG_OUT_ROWS  = 2'd2,
    CFG_MODE      = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [ROW_WIDTH_W-1:0] row_width;
    logic [OUT_SIZE_W-1:0]  out_cols;
    logic [OUT_SIZE_W-1:0]  out_rows;
    logic                   mode;
  } cfg_t;

  // one column update or block result, handed from front to back
  typedef struct packed {
    logic [KIDX_W-1:0] k;
    logic [HSUM_W-1:0] hsum;
    logic              first;
    logic              emit;
    logic              row_end;
    logic              frame_end;
    logic              mode;
  } item_t;

endpackage

### rtl/bds_front.sv
module bds_front #(
  parameter int unsigned MAX_OUT_COLS = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  bds_pkg::cfg_t                   cfg_i,
  input  logic                            accept_i,
  input  logic [bds_pkg::PIXEL_W-1:0]     pixel_i,
  input  logic                            frame_start_i,
  output logic                            push_o,
  output bds_pkg::item_t                  item_o
);

  logic [bds_pkg::COL_W-1:0]  col_q, col_d, col_cur;
  logic [bds_pkg::COL_W-1:0]  row_q, row_d, row_cur;
  logic [bds_pkg::HSUM_W-1:0] hsum_q, hsum_d, hsum_cur, h;
  logic                       done_q, done_d, done_cur;

  logic [12:0] w, oc_div, oc_a, oc, total_rows, col_inc;
  logic [10:0] orows;
  logic [14:0] oc_span;
  logic        in_range, lx_zero, lx_last, ly_zero, ly_last, wrap, re, fe;
  logic [bds_pkg::KIDX_W-1:0] k_full;

  assign col_cur  = frame_start_i ? '0 : col_q;
  assign row_cur  = frame_start_i ? '0 : row_q;
  assign hsum_cur = frame_start_i ? '0 : hsum_q;
  assign done_cur = frame_start_i ? 1'b0 : done_q;

  always_comb begin
    if (cfg_i.row_width == '0) begin
      w = 13'd1;
    end else if (cfg_i.row_width > bds_pkg::ROW_WIDTH_MAX) begin
      w = bds_pkg::ROW_WIDTH_MAX;
    end else begin
      w = cfg_i.row_width;
    end
  end

  assign oc_div = cfg_i.mode ? {2'b00, w[12:2]} : {1'b0, w[12:1]};
  assign oc_a   = (oc_div > {2'b00, cfg_i.out_cols}) ? {2'b00, cfg_i.out_cols} : oc_div;
  assign oc     = (oc_a > 13'(MAX_OUT_COLS)) ? 13'(MAX_OUT_COLS) : oc_a;
  assign orows  = (cfg_i.out_rows > bds_pkg::OUT_ROWS_MAX) ? bds_pkg::OUT_ROWS_MAX
                                                           : cfg_i.out_rows;
  assign total_rows = cfg_i.mode ? {orows, 2'b00} : {1'b0, orows, 1'b0};
  assign oc_span    = cfg_i.mode ? {oc, 2'b00} : {1'b0, oc, 1'b0};

  assign in_range = ({1'b0, row_cur} < total_rows) && ({3'b000, col_cur} < oc_span);
  assign lx_zero  = cfg_i.mode ? (col_cur[1:0] == 2'b00) : !col_cur[0];
  assign lx_last  = cfg_i.mode ? (col_cur[1:0] == 2'b11) : col_cur[0];
  assign ly_zero  = cfg_i.mode ? (row_cur[1:0] == 2'b00) : !row_cur[0];
  assign ly_last  = cfg_i.mode ? (row_cur[1:0] == 2'b11) : row_cur[0];
  assign k_full   = cfg_i.mode ? {2'b00, col_cur[11:2]} : {1'b0, col_cur[11:1]};

  assign h  = (lx_zero ? '0 : hsum_cur) + {2'b00, pixel_i};
  assign re = ({1'b0, k_full} == (oc - 13'd1));
  assign fe = re && ({1'b0, row_cur} == (total_rows - 13'd1));

  assign col_inc = {1'b0, col_cur} + 13'd1;
  assign wrap    = (col_inc >= w);

  always_comb begin
    col_d  = col_cur;
    row_d  = row_cur;
    hsum_d = hsum_cur;
    done_d = done_cur;
    if (!done_cur) begin
      if (in_range) begin
        hsum_d = h;
      end
      if (wrap) begin
        col_d = '0;
        if ((total_rows != '0) && ({1'b0, row_cur} >= (total_rows - 13'd1))) begin
          done_d = 1'b1;
        end else begin
          row_d = row_cur + 12'd1;
        end
      end else begin
        col_d = col_inc[11:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      hsum_q <= '0;
      done_q <= 1'b0;
    end else if (accept_i) begin
      col_q  <= col_d;
      row_q  <= row_d;
      hsum_q <= hsum_d;
      done_q <= done_d;
    end
  end

  // only the right-hand pixel of a block row touches the line store
  assign push_o = accept_i && !done_cur && in_range && lx_last;

  always_comb begin
    item_o.k         = k_full;
    item_o.hsum      = h;
    item_o.first     = ly_zero;
    item_o.emit      = ly_last;
    item_o.row_end   = re;
    item_o.frame_end = fe;
    item_o.mode      = cfg_i.mode;
  end

endmodule

### rtl/bds_queue.sv
module bds_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bds_pkg::item_t item_i,
  input  logic           pop_i,
  output bds_pkg::item_t head_o,
  output logic           full_o,
  output logic           empty_o
);

  bds_pkg::item_t                entry_q [bds_pkg::Q_DEPTH];
  logic [bds_pkg::Q_PTR_W-1:0]   wptr_q, rptr_q;
  logic [bds_pkg::Q_CNT_W-1:0]   cnt_q;

  assign full_o  = (cnt_q == bds_pkg::Q_CNT_W'(bds_pkg::Q_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = entry_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= item_i;
    end
  end

endmodule

### rtl/bds_back.sv
module bds_back #(
  parameter int unsigned MAX_OUT_COLS = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        empty_i,
  input  bds_pkg::item_t              head_i,
  output logic                        pop_o,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [bds_pkg::PIXEL_W-1:0] mean_o,
  output logic                        row_end_o,
  output logic                        frame_end_o
);

  localparam int unsigned KW = $clog2(MAX_OUT_COLS);

  logic [bds_pkg::TOT_W-1:0] col_mem [MAX_OUT_COLS];

  bds_pkg::item_t            s1_q;
  logic                      s1_valid_q;
  logic [bds_pkg::TOT_W-1:0] rd_q, fwd_val_q, base, tot;
  logic                      fwd_hit_q;
  logic                      out_valid_q, row_end_q, frame_end_q;
  logic [bds_pkg::PIXEL_W-1:0] mean_q;
  logic                      en, wr, emit;

  assign en    = !out_valid_q || out_ready_i;
  assign pop_o = en && !empty_i;
  assign emit  = en && s1_valid_q && s1_q.emit;
  assign wr    = en && s1_valid_q && !s1_q.emit;

  // a write to the same column in the cycle of the read is forwarded
  assign base = s1_q.first ? '0 : (fwd_hit_q ? fwd_val_q : rd_q);
  assign tot  = base + {2'b00, s1_q.hsum};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q  <= pop_o;
      out_valid_q <= s1_valid_q && s1_q.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      col_mem[s1_q.k[KW-1:0]] <= tot;
    end
    if (pop_o) begin
      rd_q      <= col_mem[head_i.k[KW-1:0]];
      s1_q      <= head_i;
      fwd_hit_q <= s1_valid_q && !s1_q.emit && (s1_q.k == head_i.k);
      fwd_val_q <= tot;
    end
    if (emit) begin
      mean_q      <= s1_q.mode ? tot[11:4] : tot[9:2];
      row_end_q   <= s1_q.row_end;
      frame_end_q <= s1_q.frame_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign mean_o      = mean_q;
  assign row_end_o   = row_end_q;
  assign frame_end_o = frame_end_q;

endmodule

### rtl/box_downsample_2x_4x.sv
// channel   | dir | fields (low bit up)
// s_axis    | in  | tdata: pixel[7:0]; tuser: frame_start
// m_axis    | out | tdata: mean_value[7:0]; tlast: row_end; tuser: frame_end
// cfg       | in  | cfg_idx_i selects register, cfg_data_i[12:0] value, cfg_we_i strobe
//
// one pixel per cycle is accepted while the 4-entry queue has room; the front
// only enqueues one line-store update per 2 or 4 pixels
// the back takes one queue entry per cycle: a registered line-store read,
// then add and write back or result into the output register
// output stalls hold the back, and input stalls once the queue fills
// reset clears counters, queue and valid flags; the line store is not cleared
module box_downsample_2x_4x #(
  parameter int unsigned MAX_OUT_COLS = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bds_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bds_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // pixel[7:0]
  input  logic [0:0]                     s_axis_tuser,  // frame_start
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [7:0]                     m_axis_tdata,  // mean_value[7:0]
  output logic                           m_axis_tlast,
  output logic [0:0]                     m_axis_tuser   // frame_end
);

  bds_pkg::cfg_t  cfg_q;
  bds_pkg::item_t push_item, head_item;
  logic           accept, q_push, q_pop, q_full, q_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row_width <= bds_pkg::ROW_WIDTH_RST;
      cfg_q.out_cols  <= bds_pkg::OUT_COLS_RST;
      cfg_q.out_rows  <= bds_pkg::OUT_ROWS_RST;
      cfg_q.mode      <= bds_pkg::MODE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bds_pkg::CFG_ROW_WIDTH: cfg_q.row_width <= cfg_data_i;
        bds_pkg::CFG_OUT_COLS:  cfg_q.out_cols  <= cfg_data_i[bds_pkg::OUT_SIZE_W-1:0];
        bds_pkg::CFG_OUT_ROWS:  cfg_q.out_rows  <= cfg_data_i[bds_pkg::OUT_SIZE_W-1:0];
        bds_pkg::CFG_MODE:      cfg_q.mode      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && !q_full;

  bds_front #(.MAX_OUT_COLS(MAX_OUT_COLS)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .accept_i      (accept),
    .pixel_i       (s_axis_tdata),
    .frame_start_i (s_axis_tuser[0]),
    .push_o        (q_push),
    .item_o        (push_item)
  );

  bds_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (push_item),
    .pop_i   (q_pop),
    .head_o  (head_item),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  bds_back #(.MAX_OUT_COLS(MAX_OUT_COLS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .head_i      (head_item),
    .pop_o       (q_pop),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .mean_o      (m_axis_tdata),
    .row_end_o   (m_axis_tlast),
    .frame_end_o (m_axis_tuser[0])
  );

  a_push_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> (s_axis_tvalid && s_axis_tready))
    else $error("queue push without an accepted transaction");

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("queue pop while empty");

  a_frame_end_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tlast)
    else $error("frame end without row end");

endmodule
